### hw/rtl/dwesm_pkg.sv
`timescale 1ns / 1ps

package dwesm_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned VALUE_W         = 64;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_SIGNED   = 2'd0;
	localparam kind_t KIND_UNSIGNED = 2'd1;
	localparam kind_t KIND_ADDRESS  = 2'd2;
	localparam kind_t KIND_REGISTER = 2'd3;

	typedef enum logic [1:0] {
		RUN_EXEC = 2'd0,
		RUN_DONE = 2'd1,
		RUN_FAIL = 2'd2
	} run_state_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_UNHANDLED = 3'd1,
		ERR_TYPE      = 3'd2,
		ERR_UNDER     = 3'd3,
		ERR_OVER      = 3'd4,
		ERR_FETCH     = 3'd5
	} err_t;

	typedef logic [1:0] loc_t;

	localparam loc_t LOC_ADDRESS  = 2'd0;
	localparam loc_t LOC_REGISTER = 2'd1;
	localparam loc_t LOC_NONE     = 2'd2;
	localparam loc_t LOC_OTHER    = 2'd3;

	// DW_OP codes
	localparam logic [7:0] OP_ADDR   = 8'h03;
	localparam logic [7:0] OP_LOAD   = 8'h06;
	localparam logic [7:0] OP_DUP    = 8'h12;
	localparam logic [7:0] OP_DROP   = 8'h13;
	localparam logic [7:0] OP_PLUS   = 8'h22;
	localparam logic [7:0] OP_LIT0   = 8'h30;
	localparam logic [7:0] OP_LIT31  = 8'h4f;
	localparam logic [7:0] OP_REG0   = 8'h50;
	localparam logic [7:0] OP_REG31  = 8'h6f;
	localparam logic [7:0] OP_BREG0  = 8'h70;
	localparam logic [7:0] OP_BREG31 = 8'h8f;
	localparam logic [7:0] OP_FBREG  = 8'h91;

	typedef struct packed {
		kind_t               kind;
		logic [VALUE_W-1:0]  value;
	} entry_t;

endpackage

### hw/rtl/dwesm_cmd_if.sv
`timescale 1ns / 1ps

interface dwesm_cmd_if;
	logic        valid;
	logic        ready;
	logic        start_new;
	logic        is_end;
	logic [7:0]  opcode;
	logic [63:0] operand;
	logic [63:0] external_value;
	logic        external_ok;

	modport source (
		output valid, start_new, is_end, opcode, operand, external_value, external_ok,
		input  ready
	);
	modport sink (
		input  valid, start_new, is_end, opcode, operand, external_value, external_ok,
		output ready
	);
	modport mon (
		input valid, ready, start_new, is_end, opcode, operand, external_value, external_ok
	);
endinterface

### hw/rtl/dwesm_rsp_if.sv
`timescale 1ns / 1ps

interface dwesm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  machine_state;
	logic [2:0]  error_code;
	logic [4:0]  stack_count;
	logic        top_valid;
	logic [1:0]  top_kind;
	logic [63:0] top_value;
	logic [1:0]  location_code;

	modport source (
		output valid, machine_state, error_code, stack_count, top_valid, top_kind,
		       top_value, location_code,
		input  ready
	);
	modport sink (
		input  valid, machine_state, error_code, stack_count, top_valid, top_kind,
		       top_value, location_code,
		output ready
	);
	modport mon (
		input valid, ready, machine_state, error_code, stack_count, top_valid, top_kind,
		      top_value, location_code
	);
endinterface

### hw/rtl/dwesm_ram.sv
`timescale 1ns / 1ps

module dwesm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/dwarf_expression_stack_machine.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Item
// cmd      in   valid / ready  start_new, is_end, opcode, operand, external_value, external_ok
// rsp      out  valid / ready  machine_state, error_code, stack_count, top_valid, top_kind,
//                              top_value, location_code
//
// One item per cycle: each accepted cmd item is executed in its accept cycle and its
// result lands in the rsp register at the end of that cycle.
// Rate is set by the single read-modify-write of the stack RAM and top register.
// cmd.ready is high whenever rsp is empty or being taken; a stall on rsp holds cmd.
// arst_n clears depth, run state, error and the rsp valid; the stack RAM is not cleared.

module dwarf_expression_stack_machine #(
	parameter int unsigned STACK_DEPTH = dwesm_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dwesm_cmd_if.sink   cmd,
	dwesm_rsp_if.source rsp
);

	localparam int unsigned DW = $clog2(STACK_DEPTH + 1); // depth counter
	localparam int unsigned AW = $clog2(STACK_DEPTH);     // RAM index
	localparam int unsigned EW = $bits(dwesm_pkg::entry_t);

	// Stack layout: top entry lives in top_q, everything below it in the RAM at
	// index (position). The RAM read port always points at depth-2, so its registered
	// data is the next-on-stack entry. A push writes the old top at
	// depth-1, which is exactly the next read address: that case is bypassed.

	logic [DW-1:0]          depth_q;
	dwesm_pkg::run_state_t  run_q;
	dwesm_pkg::err_t        err_q;
	dwesm_pkg::entry_t      top_q;
	logic                   byp_q;
	dwesm_pkg::entry_t      byp_data_q;

	logic                   rsp_valid_q;
	logic [1:0]             rsp_state_q;
	logic [2:0]             rsp_err_q;
	logic [4:0]             rsp_count_q;
	logic                   rsp_top_valid_q;
	logic [1:0]             rsp_kind_q;
	logic [63:0]            rsp_value_q;
	logic [1:0]             rsp_loc_q;

	logic                   accept;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;

	// next-state
	logic [DW-1:0]          d;
	logic [DW-1:0]          d_nx;
	dwesm_pkg::run_state_t  rs;
	dwesm_pkg::run_state_t  rs_nx;
	dwesm_pkg::err_t        er;
	dwesm_pkg::err_t        er_nx;
	dwesm_pkg::entry_t      nos;
	dwesm_pkg::entry_t      top_nx;
	dwesm_pkg::entry_t      push_e;
	logic                   push;
	logic                   fail;
	dwesm_pkg::err_t        fail_code;
	logic [7:0]             opc_off;
	logic [DW-1:0]          wptr;
	logic [DW-1:0]          rptr;
	logic [31:0]            count_ext;
	logic                   have_top;
	dwesm_pkg::loc_t        loc;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign nos = byp_q ? byp_data_q : dwesm_pkg::entry_t'(ram_rdata);

	always_comb begin
		d         = cmd.start_new ? '0 : depth_q;
		rs        = cmd.start_new ? dwesm_pkg::RUN_EXEC : run_q;
		er        = cmd.start_new ? dwesm_pkg::ERR_NONE : err_q;
		d_nx      = d;
		rs_nx     = rs;
		er_nx     = er;
		top_nx    = top_q;
		push      = 1'b0;
		push_e    = top_q;
		fail      = 1'b0;
		fail_code = dwesm_pkg::ERR_NONE;
		opc_off   = '0;
		ram_we    = 1'b0;

		if (cmd.is_end) begin
			if (rs == dwesm_pkg::RUN_EXEC) begin
				rs_nx = dwesm_pkg::RUN_DONE;
			end
		end else if (rs == dwesm_pkg::RUN_EXEC) begin
			unique case (cmd.opcode) inside
				[dwesm_pkg::OP_LIT0 : dwesm_pkg::OP_LIT31]: begin
					opc_off = cmd.opcode - dwesm_pkg::OP_LIT0;
					push    = 1'b1;
					push_e  = '{kind: dwesm_pkg::KIND_UNSIGNED, value: {56'd0, opc_off}};
				end
				[dwesm_pkg::OP_REG0 : dwesm_pkg::OP_REG31]: begin
					opc_off = cmd.opcode - dwesm_pkg::OP_REG0;
					push    = 1'b1;
					push_e  = '{kind: dwesm_pkg::KIND_REGISTER, value: {56'd0, opc_off}};
				end
				[dwesm_pkg::OP_BREG0 : dwesm_pkg::OP_BREG31], dwesm_pkg::OP_FBREG: begin
					if (!cmd.external_ok) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_FETCH;
					end else begin
						push   = 1'b1;
						push_e = '{kind: dwesm_pkg::KIND_ADDRESS,
						           value: cmd.external_value + cmd.operand};
					end
				end
				dwesm_pkg::OP_ADDR: begin
					push   = 1'b1;
					push_e = '{kind: dwesm_pkg::KIND_ADDRESS, value: cmd.operand};
				end
				dwesm_pkg::OP_DUP: begin
					if (d == '0) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_UNDER;
					end else begin
						push   = 1'b1;
						push_e = top_q;
					end
				end
				dwesm_pkg::OP_DROP: begin
					if (d == '0) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_UNDER;
					end else begin
						d_nx   = d - DW'(1);
						top_nx = nos;
					end
				end
				dwesm_pkg::OP_LOAD: begin
					if (d == '0) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_UNDER;
					end else if (top_q.kind != dwesm_pkg::KIND_ADDRESS) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_TYPE;
					end else if (!cmd.external_ok) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_FETCH;
					end else begin
						top_nx.value = cmd.external_value;
					end
				end
				dwesm_pkg::OP_PLUS: begin
					if (d < DW'(2)) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_UNDER;
					end else if (top_q.kind != nos.kind ||
					             (top_q.kind != dwesm_pkg::KIND_UNSIGNED &&
					              top_q.kind != dwesm_pkg::KIND_SIGNED)) begin
						fail      = 1'b1;
						fail_code = dwesm_pkg::ERR_TYPE;
					end else begin
						d_nx   = d - DW'(1);
						top_nx = '{kind: top_q.kind, value: top_q.value + nos.value};
					end
				end
				default: begin
					fail      = 1'b1;
					fail_code = dwesm_pkg::ERR_UNHANDLED;
				end
			endcase

			if (push) begin
				if (d == DW'(STACK_DEPTH)) begin
					fail      = 1'b1;
					fail_code = dwesm_pkg::ERR_OVER;
				end else begin
					// old top sinks into the RAM unless the stack was empty
					ram_we = accept && (d != '0);
					top_nx = push_e;
					d_nx   = d + DW'(1);
				end
			end

			if (fail) begin
				rs_nx = dwesm_pkg::RUN_FAIL;
				er_nx = fail_code;
			end
		end
	end

	// RAM addressing: write at depth-1, read at (new) depth-2
	assign wptr      = d - DW'(1);
	assign ram_waddr = wptr[AW-1:0];
	assign rptr      = (accept ? d_nx : depth_q) - DW'(2);
	assign ram_raddr = rptr[AW-1:0];

	dwesm_ram #(
		.WIDTH (EW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result fields
	assign have_top  = d_nx != '0;
	assign count_ext = 32'(d_nx);

	always_comb begin
		loc = dwesm_pkg::LOC_ADDRESS;
		if (cmd.is_end) begin
			if (rs_nx == dwesm_pkg::RUN_FAIL || !have_top) begin
				loc = dwesm_pkg::LOC_NONE;
			end else if (top_nx.kind == dwesm_pkg::KIND_ADDRESS) begin
				loc = dwesm_pkg::LOC_ADDRESS;
			end else if (top_nx.kind == dwesm_pkg::KIND_REGISTER) begin
				loc = dwesm_pkg::LOC_REGISTER;
			end else begin
				loc = dwesm_pkg::LOC_OTHER;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			run_q       <= dwesm_pkg::RUN_EXEC;
			err_q       <= dwesm_pkg::ERR_NONE;
			byp_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			byp_q <= ram_we;
			if (accept) begin
				depth_q <= d_nx;
				run_q   <= rs_nx;
				err_q   <= er_nx;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ram_we) begin
			byp_data_q <= top_q;
		end
		if (accept) begin
			top_q           <= top_nx;
			rsp_state_q     <= rs_nx;
			rsp_err_q       <= er_nx;
			rsp_count_q     <= count_ext[4:0];
			rsp_top_valid_q <= have_top;
			rsp_kind_q      <= have_top ? top_nx.kind : dwesm_pkg::KIND_SIGNED;
			rsp_value_q     <= have_top ? top_nx.value : 64'd0;
			rsp_loc_q       <= loc;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.machine_state = rsp_state_q;
	assign rsp.error_code    = rsp_err_q;
	assign rsp.stack_count   = rsp_count_q;
	assign rsp.top_valid     = rsp_top_valid_q;
	assign rsp.top_kind      = rsp_kind_q;
	assign rsp.top_value     = rsp_value_q;
	assign rsp.location_code = rsp_loc_q;

endmodule

### hw/rtl/dwesm_checker.sv
`timescale 1ns / 1ps

module dwesm_checker (
	input logic         clk,
	input logic         arst_n,
	dwesm_cmd_if.sink   cmd,
	dwesm_rsp_if.source rsp
);

	// every accepted item yields a result on the next edge
	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> rsp.valid)
	else $error("accepted item without result");

	// an empty stack reports zero kind and value
	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.top_valid |-> rsp.top_value == 64'd0 && rsp.top_kind == 2'd0)
	else $error("empty stack shows a top entry");

	// error code is set exactly when the machine has failed
	a_fail_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.machine_state == dwesm_pkg::RUN_FAIL) ==
		               (rsp.error_code != dwesm_pkg::ERR_NONE)))
	else $error("failed state and error code disagree");

	// a stalled result stays valid and holds its top value and stack count
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.top_value) &&
		$stable(rsp.stack_count))
	else $error("result changed while stalled");

endmodule

bind dwarf_expression_stack_machine dwesm_checker u_dwesm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.rsp    (rsp)
);
